// ===== src/bfs_pkg.sv =====
// Shared types, constants and hash helpers for the 64-bit stream Bloom filter.
// No dependencies; imported by every module of the block.
package bfs_pkg;

    localparam int DEFAULT_MAX_HASHES = 8;
    localparam int HASH_BASE          = 5381;
    localparam int FILTER_BITS        = 64;
    localparam int IDX_W              = 6;
    localparam int HCOUNT_W           = 4;

    localparam logic [HCOUNT_W-1:0] HASH_COUNT_RESET = 4'd3;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] key_byte;
        logic       key_last;
    } in_beat_t;

    typedef struct packed {
        logic                   maybe_present;
        logic [FILTER_BITS-1:0] filter_bits;
    } out_beat_t;

    // Start value of one seeded hash, reduced to the filter index width
    function automatic logic [IDX_W-1:0] seed_start(input int idx);
        return IDX_W'((HASH_BASE + idx) % FILTER_BITS);
    endfunction

    // One hash step on the low six bits: h*33 is h + (h << 5), then xor byte
    function automatic logic [IDX_W-1:0] hash_step(input logic [IDX_W-1:0] h,
                                                   input logic [7:0] b);
        return (h + {h[0], 5'b0_0000}) ^ b[IDX_W-1:0];
    endfunction

endpackage

// ===== src/bfs_hash_cell.sv =====
// One seeded hash cell: holds its running hash and ORs its filter bit into the
// mask handed along the row. Depends on bfs_pkg.
module bfs_hash_cell import bfs_pkg::*; #(
    parameter int SEED_IDX = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  logic                   key_end,
    input  logic [7:0]             key_byte,
    input  logic [HCOUNT_W-1:0]    hash_count,
    input  logic [FILTER_BITS-1:0] mask_in,
    output logic [FILTER_BITS-1:0] mask_out
);

    localparam logic [IDX_W-1:0] SEED = seed_start(SEED_IDX);

    logic [IDX_W-1:0] hash_reg;
    logic [IDX_W-1:0] hash_next;
    logic [IDX_W-1:0] hash_upd;
    logic             enable;

    assign hash_upd = hash_step(hash_reg, key_byte);
    assign enable   = hash_count > HCOUNT_W'(SEED_IDX);

    // Add this cell's bit to the mask when it is among the active seeds
    always_comb begin
        mask_out = mask_in;
        if (enable) begin
            mask_out = mask_in | (FILTER_BITS'(1) << hash_upd);
        end
    end

    // Advance on each byte, reload the seed after a key's last byte
    always_comb begin
        hash_next = hash_reg;
        if (load) begin
            hash_next = key_end ? SEED : hash_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= SEED;
        end else begin
            hash_reg <= hash_next;
        end
    end

endmodule

// ===== src/bfs_out_queue.sv =====
// Two-entry result queue that decouples the result channel from the input.
// Depends on bfs_pkg for the result beat type.
module bfs_out_queue import bfs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_beat_t push_data,
    output logic      full,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    out_beat_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = count_reg != 2'd0;
    assign full    = count_reg == 2'd2;
    assign m_data  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/bloom_filter_64bit_stream_core.sv =====
// Stream Bloom filter over a 64-bit word with a row of seeded hash cells.
// Depends on bfs_pkg, bfs_hash_cell and bfs_out_queue.
//
// Usage:
//   Input channel (s_valid/s_ready/s_data): one key byte per beat, with the
//   operation (add or query) and a last-byte flag. Only the operation on the
//   last byte counts.
//   Result channel (m_valid/m_ready/m_data): one beat per key, sent for the
//   key's last byte: maybe_present (query hit, or 1 for an add) and the
//   filter word after the operation.
//   Config channel (cfg_valid/cfg_ready/cfg_data): writes hash_count; any
//   value above MAX_HASHES acts as MAX_HASHES. Always ready.
// Result: a key's result is queued when its last byte is accepted.
// Throughput: one byte per cycle while s_ready is high; each hash cell updates
// in the same cycle; the mask chain across the MAX_HASHES cells closes in it.
// Stall: a two-entry result queue absorbs results; s_ready drops only when
// both entries wait on m_ready.
// Reset: filter cleared, hashes at their seeds, hash_count = 3, queue empty.
module bloom_filter_64bit_stream_core import bfs_pkg::*; #(
    parameter int MAX_HASHES = DEFAULT_MAX_HASHES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_beat_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_beat_t           m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [HCOUNT_W-1:0] cfg_data
);

    logic [HCOUNT_W-1:0]    hash_count_reg;
    logic [FILTER_BITS-1:0] filter_reg;
    logic [FILTER_BITS-1:0] filter_next;
    logic [FILTER_BITS-1:0] mask_chain [MAX_HASHES+1];
    logic [FILTER_BITS-1:0] mask;
    logic                   accept;
    logic                   key_end;
    logic                   queue_full;
    out_beat_t              result;

    assign s_ready   = !queue_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign key_end   = accept && s_data.key_last;

    // Row of hash cells, each handing its mask to the next
    assign mask_chain[0] = '0;

    for (genvar i = 0; i < MAX_HASHES; i++) begin : g_cell
        bfs_hash_cell #(
            .SEED_IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .load       (accept),
            .key_end    (s_data.key_last),
            .key_byte   (s_data.key_byte),
            .hash_count (hash_count_reg),
            .mask_in    (mask_chain[i]),
            .mask_out   (mask_chain[i+1])
        );
    end

    assign mask = mask_chain[MAX_HASHES];

    // Apply the key on its last byte
    always_comb begin
        filter_next          = filter_reg;
        result.maybe_present = 1'b1;
        result.filter_bits   = filter_reg;
        if (s_data.operation == OP_ADD) begin
            filter_next        = filter_reg | mask;
            result.filter_bits = filter_reg | mask;
        end else begin
            result.maybe_present = (filter_reg & mask) == mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg     <= '0;
            hash_count_reg <= HASH_COUNT_RESET;
        end else begin
            if (key_end) begin
                filter_reg <= filter_next;
            end
            if (cfg_valid) begin
                hash_count_reg <= cfg_data;
            end
        end
    end

    // Hold results until the receiver takes them
    bfs_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (key_end),
        .push_data (result),
        .full      (queue_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
